// ----- design/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared sizes, register codes and cell control structs for the page frame
// replacement unit.
// ----------------------------------------------------------------------------
package pfr_pkg;

    // Frame storage and field sizes
    localparam int FRAMES        = 8;
    localparam int PAGE_BITS     = 16;
    localparam int SLOT_W        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W        = SLOT_W;
    localparam int USED_W        = $clog2(FRAMES + 1);
    localparam int SLOT_OUT_W    = 3;
    localparam int FAULT_W       = 32;
    localparam int FRAME_COUNT_W = 4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_POLICY      = 1'b1;

    // Policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Reset values of the registers
    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = FRAME_COUNT_W'(8);
    localparam logic                     POLICY_RST      = POLICY_LRU;

    // Lookup data broadcast to every cell
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [USED_W-1:0]    used;
        logic [RANK_W-1:0]    victim_rank;
    } t_cell_cmd;

    // Update broadcast to every cell when a request is taken
    typedef struct packed {
        logic                 en;
        logic [SLOT_W-1:0]    slot;
        logic                 wr;
        logic [PAGE_BITS-1:0] page;
        logic                 lru;
        logic                 promote_all;
        logic [RANK_W-1:0]    limit;
    } t_cell_upd;

    // Status returned by each cell
    typedef struct packed {
        logic                 hit;
        logic                 victim;
        logic [PAGE_BITS-1:0] page;
        logic [RANK_W-1:0]    rank;
    } t_cell_stat;

endpackage

// ----- design/pfr_req_if.sv -----
// ----------------------------------------------------------------------------
// pfr_req_if
// Request channel: one page number per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfr_req_if;
    import pfr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

// ----- design/pfr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pfr_rsp_if
// Response channel: fault flag, slot, evicted page and fault count.
// ----------------------------------------------------------------------------
interface pfr_rsp_if;
    import pfr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  page_fault;
    logic [SLOT_OUT_W-1:0] frame_slot;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [FAULT_W-1:0]    fault_total;

    modport source (output valid, output page_fault, output frame_slot,
                    output evicted_valid, output evicted_page,
                    output fault_total, input ready);
    modport sink   (input valid, input page_fault, input frame_slot,
                    input evicted_valid, input evicted_page,
                    input fault_total, output ready);
endinterface

// ----- design/pfr_cell.sv -----
// ----------------------------------------------------------------------------
// pfr_cell
// One page frame: holds its page and recency rank, compares against the
// request and passes first-match flags on to the next cell of the chain.
// ----------------------------------------------------------------------------
module pfr_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic [pfr_pkg::SLOT_W-1:0] i_slot,
    input  pfr_pkg::t_cell_cmd        i_cmd,
    input  pfr_pkg::t_cell_upd        i_upd,
    input  logic                      i_hit_seen,
    input  logic                      i_vic_seen,
    output logic                      o_hit_seen,
    output logic                      o_vic_seen,
    output pfr_pkg::t_cell_stat       o_stat
);
    import pfr_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic [RANK_W-1:0]    r_rank;
    logic                 occupied;
    logic                 match;
    logic                 vmatch;

    // Compare against the request; only the first match along the chain wins
    assign occupied   = USED_W'(i_slot) < i_cmd.used;
    assign match      = occupied && (r_page == i_cmd.page);
    assign vmatch     = occupied && (r_rank == i_cmd.victim_rank);
    assign o_hit_seen = i_hit_seen | match;
    assign o_vic_seen = i_vic_seen | vmatch;

    assign o_stat.hit    = match & ~i_hit_seen;
    assign o_stat.victim = vmatch & ~i_vic_seen;
    assign o_stat.page   = r_page;
    assign o_stat.rank   = r_rank;

    // Install the new page in the target frame
    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.wr && (i_slot == i_upd.slot)) begin
            r_page <= i_upd.page;
        end
    end

    // Promote the target to most recent; under LRU age the more recent frames, or all on a miss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_rank <= '0;
        end else if (i_upd.en) begin
            if (i_slot == i_upd.slot) begin
                if (i_upd.lru || i_upd.wr) begin
                    r_rank <= '0;
                end
            end else if (i_upd.lru && occupied &&
                         (i_upd.promote_all || (r_rank < i_upd.limit))) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

endmodule

// ----- design/page_frame_replacement.sv -----
// ----------------------------------------------------------------------------
// page_frame_replacement
// FIFO / LRU page frame replacement unit built as a chain of frame cells.
// ----------------------------------------------------------------------------
// Takes one page request per clock and returns its result in the next cycle
// from an output register; a new request is taken in the same cycle the
// previous result is taken, so with a ready sink the rate is one per cycle.
// The cycle is set by the lookup: all frame cells compare the page in
// parallel, a first-match chain runs through the cells, and the chosen slot
// feeds back to every cell's rank update. Writing frame_count (offset 0) or
// policy_select (offset 4) clears all frames and the fault count; write them
// only while no request is in flight.
module page_frame_replacement (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pfr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pfr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    pfr_req_if.sink                           i_req,
    pfr_rsp_if.source                         o_rsp
);
    import pfr_pkg::*;

    // Configuration registers
    logic [FRAME_COUNT_W-1:0] r_frame_count;
    logic                     r_policy;
    logic                     cfg_wr;
    logic                     cfg_idx;

    // Frame bookkeeping
    logic [USED_W-1:0]  r_frames_used;
    logic [SLOT_W-1:0]  r_insert_ptr;
    logic [FAULT_W-1:0] r_fault_counter;

    // Output register
    logic                 r_out_valid;
    logic                 r_fault;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page;

    // Lookup
    t_cell_cmd          cmd;
    t_cell_upd          upd;
    t_cell_stat         stat [FRAMES];
    logic [FRAMES:0]    hit_seen;
    logic [FRAMES:0]    vic_seen;
    logic [FRAMES-1:0]  hit_vec;
    logic [FRAMES-1:0]  vic_vec;
    logic               accept;
    logic               hit;
    logic               full;
    logic               lru;
    logic [USED_W-1:0]  active;
    logic [SLOT_W-1:0]  hit_slot;
    logic [RANK_W-1:0]  hit_rank;
    logic [SLOT_W-1:0]  vic_slot;
    logic [SLOT_W-1:0]  slot;
    logic               ev_valid;
    logic [PAGE_BITS-1:0] ev_page;

    // APB write decode and read back
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            REG_FRAME_COUNT: prdata = APB_DATA_W'(r_frame_count);
            REG_POLICY:      prdata = APB_DATA_W'(r_policy);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
            r_policy      <= POLICY_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_COUNT: r_frame_count <= pwdata[FRAME_COUNT_W-1:0];
                REG_POLICY:      r_policy      <= pwdata[0];
                default:         r_policy      <= r_policy;
            endcase
        end
    end

    // Saturate frame count into 1..FRAMES
    always_comb begin
        if (r_frame_count == '0) begin
            active = USED_W'(1);
        end else if (int'(r_frame_count) > FRAMES) begin
            active = USED_W'(FRAMES);
        end else begin
            active = USED_W'(r_frame_count);
        end
    end

    assign lru    = (r_policy == POLICY_LRU);
    assign full   = (r_frames_used == active);
    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_valid || o_rsp.ready;

    // Broadcast the lookup to the cells
    assign cmd.page        = i_req.page_number;
    assign cmd.used        = r_frames_used;
    assign cmd.victim_rank = RANK_W'(r_frames_used - USED_W'(1));

    assign hit_seen[0] = 1'b0;
    assign vic_seen[0] = 1'b0;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        pfr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (cfg_wr),
            .i_slot     (SLOT_W'(g)),
            .i_cmd      (cmd),
            .i_upd      (upd),
            .i_hit_seen (hit_seen[g]),
            .i_vic_seen (vic_seen[g]),
            .o_hit_seen (hit_seen[g+1]),
            .o_vic_seen (vic_seen[g+1]),
            .o_stat     (stat[g])
        );
        assign hit_vec[g] = stat[g].hit;
        assign vic_vec[g] = stat[g].victim;
    end

    // Encode the winning cells
    always_comb begin
        hit_slot = '0;
        hit_rank = '0;
        vic_slot = '0;
        for (int s = 0; s < FRAMES; s++) begin
            if (hit_vec[s]) begin
                hit_slot = hit_slot | SLOT_W'(s);
                hit_rank = hit_rank | stat[s].rank;
            end
            if (vic_vec[s]) begin
                vic_slot = vic_slot | SLOT_W'(s);
            end
        end
    end

    assign hit = hit_seen[FRAMES];

    // Pick the slot: hit, free frame, or victim
    always_comb begin
        if (hit) begin
            slot = hit_slot;
        end else if (!full) begin
            slot = SLOT_W'(r_frames_used);
        end else if (lru) begin
            slot = vic_slot;
        end else begin
            slot = r_insert_ptr;
        end
    end

    assign ev_valid = !hit && full;
    assign ev_page  = ev_valid ? stat[slot].page : '0;

    // Drive the cell update
    assign upd.en          = accept;
    assign upd.slot        = slot;
    assign upd.wr          = !hit;
    assign upd.page        = i_req.page_number;
    assign upd.lru         = lru;
    assign upd.promote_all = !hit;
    assign upd.limit       = hit_rank;

    // Advance occupancy, insert pointer and fault count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_frames_used   <= '0;
            r_insert_ptr    <= '0;
            r_fault_counter <= '0;
        end else if (accept && !hit) begin
            if (!full) begin
                r_frames_used <= r_frames_used + USED_W'(1);
            end else if (!lru) begin
                if (USED_W'(r_insert_ptr) + USED_W'(1) == active) begin
                    r_insert_ptr <= '0;
                end else begin
                    r_insert_ptr <= r_insert_ptr + SLOT_W'(1);
                end
            end
            if (r_fault_counter != '1) begin
                r_fault_counter <= r_fault_counter + FAULT_W'(1);
            end
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fault    <= !hit;
            r_slot     <= slot;
            r_ev_valid <= ev_valid;
            r_ev_page  <= ev_page;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.page_fault    = r_fault;
    assign o_rsp.frame_slot    = SLOT_OUT_W'(r_slot);
    assign o_rsp.evicted_valid = r_ev_valid;
    assign o_rsp.evicted_page  = r_ev_page;
    assign o_rsp.fault_total   = r_fault_counter;

    // Checks
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames_used <= active)
        else $error("frames_used beyond active frame count");

    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_vec) && $onehot0(vic_vec))
        else $error("more than one first match in the cell chain");

    a_lru_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !hit && full && lru) |-> $onehot(vic_vec))
        else $error("no least recent frame found on a full LRU miss");

    a_fifo_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !lru |-> (USED_W'(r_insert_ptr) < active))
        else $error("insert pointer outside active frames");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_out_valid && (r_fault == $past(!hit))))
        else $error("result not loaded after a taken request");

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page frame replacement unit. A local model of
// the frame table tracks resident pages, FIFO insert order and LRU ranks, and
// predicts fault, slot, evicted page and fault count for every accepted page
// request. Directed cases cover fill, hit, eviction and the frame count
// limits under both policies. Random phases then run locality-heavy traffic
// under many register settings, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STALL_PHASE_LEN = 97;
    localparam logic [APB_ADDR_W-1:0] ADDR_FRAME_COUNT = {REG_FRAME_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_POLICY      = {REG_POLICY, 2'b00};

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_mode;

    typedef struct packed {
        logic                  page_fault;
        logic [SLOT_OUT_W-1:0] frame_slot;
        logic                  evicted_valid;
        logic [PAGE_BITS-1:0]  evicted_page;
        logic [FAULT_W-1:0]    fault_total;
    } t_lookup_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pfr_req_if req ();
    pfr_rsp_if rsp ();

    page_frame_replacement dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Model of the frame table
    logic [PAGE_BITS-1:0]     model_page [FRAMES];
    logic [RANK_W-1:0]        model_rank [FRAMES];
    logic [USED_W-1:0]        model_used;
    logic [SLOT_W-1:0]        model_insert;
    logic [FAULT_W-1:0]       model_faults;
    logic [FRAME_COUNT_W-1:0] model_frame_count;
    logic                     model_policy;

    t_lookup_result expected_lookups [$];
    int error_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit gaps_enabled = 1'b1;

    int          stall_phase_cycle = 0;
    t_stall_mode stall_mode = STALL_NONE;
    logic [7:0]  stall_mask = 8'hFF;

    // Clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void clear_frames();
        for (int s = 0; s < FRAMES; s++) begin
            model_page[s] = '0;
            model_rank[s] = '0;
        end
        model_used   = '0;
        model_insert = '0;
        model_faults = '0;
    endfunction

    function automatic int active_frames();
        if (model_frame_count == '0) return 1;
        if (model_frame_count > FRAMES) return FRAMES;
        return int'(model_frame_count);
    endfunction

    // Make a slot most recent; occupied slots ranked below the limit age by one
    function automatic void promote_slot(int slot, int limit);
        for (int s = 0; s < int'(model_used); s++) begin
            if (s != slot && int'(model_rank[s]) < limit) model_rank[s] = model_rank[s] + 1'b1;
        end
        model_rank[slot] = '0;
    endfunction

    function automatic t_lookup_result predict_lookup(logic [PAGE_BITS-1:0] page);
        t_lookup_result r;
        int             n;
        int             slot;
        bit             hit;
        bit             found;
        r     = '0;
        n     = active_frames();
        slot  = 0;
        hit   = 1'b0;
        found = 1'b0;
        for (int s = 0; s < int'(model_used); s++) begin
            if (!hit && model_page[s] == page) begin
                hit  = 1'b1;
                slot = s;
            end
        end
        if (hit) begin
            if (model_policy == POLICY_LRU) promote_slot(slot, int'(model_rank[slot]));
        end else begin
            if (int'(model_used) < n) begin
                // Fill the next free frame
                slot = int'(model_used);
                model_page[slot] = page;
                model_rank[slot] = '0;
                model_used = model_used + 1'b1;
                if (model_policy == POLICY_LRU) promote_slot(slot, FRAMES + 1);
            end else begin
                // Pick the victim: least recent rank or oldest insert
                if (model_policy == POLICY_LRU) begin
                    for (int s = 0; s < int'(model_used); s++) begin
                        if (!found && int'(model_rank[s]) == int'(model_used) - 1) begin
                            found = 1'b1;
                            slot  = s;
                        end
                    end
                end else begin
                    slot = int'(model_insert) % n;
                    model_insert = SLOT_W'((slot + 1) % n);
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = model_page[slot];
                model_page[slot] = page;
                if (model_policy == POLICY_LRU) promote_slot(slot, FRAMES + 1);
            end
            if (model_faults != '1) model_faults = model_faults + 1'b1;
        end
        r.page_fault  = !hit;
        r.frame_slot  = SLOT_OUT_W'(slot);
        r.fault_total = model_faults;
        return r;
    endfunction

    // Predict each request as it is taken
    always @(posedge i_clk) begin
        t_lookup_result pred;
        if (i_rst_n && req.valid && req.ready) begin
            pred = predict_lookup(req.page_number);
            expected_lookups.insert(expected_lookups.size(), pred);
        end
    end

    // Compare each response with the oldest prediction
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (expected_lookups.size() == 0) begin
                $error("unexpected response: slot %0d fault %0d", rsp.frame_slot,
                       rsp.page_fault);
                error_count++;
            end else begin
                want = expected_lookups.pop_front();
                if (rsp.page_fault !== want.page_fault) begin
                    $error("page_fault: expected %0d, got %0d", want.page_fault, rsp.page_fault);
                    error_count++;
                end
                if (rsp.frame_slot !== want.frame_slot) begin
                    $error("frame_slot: expected %0d, got %0d", want.frame_slot, rsp.frame_slot);
                    error_count++;
                end
                if (rsp.evicted_valid !== want.evicted_valid) begin
                    $error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
                           rsp.evicted_valid);
                    error_count++;
                end
                if (rsp.evicted_page !== want.evicted_page) begin
                    $error("evicted_page: expected 0x%04h, got 0x%04h", want.evicted_page,
                           rsp.evicted_page);
                    error_count++;
                end
                if (rsp.fault_total !== want.fault_total) begin
                    $error("fault_total: expected %0d, got %0d", want.fault_total,
                           rsp.fault_total);
                    error_count++;
                end
            end
        end
    end

    // Stall the response side; switch between stall styles every phase
    always @(posedge i_clk) begin
        stall_phase_cycle++;
        if (stall_phase_cycle >= STALL_PHASE_LEN) begin
            stall_phase_cycle = 0;
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_mask = 8'($urandom) | 8'h01;
        end
        case (stall_mode)
            STALL_NONE:   rsp.ready <= 1'b1;
            STALL_RANDOM: rsp.ready <= ($urandom_range(0, 3) != 0);
            default:      rsp.ready <= stall_mask[stall_phase_cycle % 8];
        endcase
    end

    // Abort if nothing moves for too long
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic apb_transfer(input logic write, input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] data,
                                output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input logic [APB_ADDR_W-1:0] addr);
        logic [APB_DATA_W-1:0] rdata;
        logic [APB_DATA_W-1:0] want;
        want = (addr == ADDR_FRAME_COUNT) ? APB_DATA_W'(model_frame_count)
                                          : APB_DATA_W'(model_policy);
        apb_transfer(1'b0, addr, '0, rdata);
        if (rdata !== want) begin
            $error("register 0x%0h: expected 0x%0h, got 0x%0h", addr, want, rdata);
            error_count++;
        end
    endtask

    // Write a register, mirror it in the model, then read it back
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] unused;
        apb_transfer(1'b1, addr, data, unused);
        if (addr == ADDR_FRAME_COUNT) begin
            model_frame_count = data[FRAME_COUNT_W-1:0];
            clear_frames();
        end else if (addr == ADDR_POLICY) begin
            model_policy = data[0];
            clear_frames();
        end
        check_register(addr);
    endtask

    // Hold one request until it is taken
    task automatic send_page_request(input logic [PAGE_BITS-1:0] page);
        req.valid       <= 1'b1;
        req.page_number <= page;
        do @(posedge i_clk); while (!req.ready);
    endtask

    // Insert a random gap at the end of each burst when gaps are enabled
    task automatic pace_sender();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_enabled) begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_pages(input logic [PAGE_BITS-1:0] pages [$]);
        foreach (pages[i]) begin
            send_page_request(pages[i]);
            pace_sender();
        end
    endtask

    // Drop valid and wait on clock edges until every prediction is matched
    task automatic drain_results();
        req.valid <= 1'b0;
        do @(posedge i_clk); while (expected_lookups.size() != 0);
    endtask

    task automatic test_lru_fill_and_evict();
        check_register(ADDR_FRAME_COUNT);
        check_register(ADDR_POLICY);
        // Page zero misses even though empty frames hold zero
        send_pages('{16'h0000, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h0001,
                     16'h0002, 16'h0003, 16'h0004, 16'hFFFF, 16'h0005});
        drain_results();
    endtask

    task automatic test_fifo_small();
        write_register(ADDR_POLICY, APB_DATA_W'(POLICY_FIFO));
        write_register(ADDR_FRAME_COUNT, APB_DATA_W'(2));
        // A hit leaves the insert order untouched
        send_pages('{16'h0007, 16'h0009, 16'h0007, 16'h000B, 16'h0009, 16'h000D});
        drain_results();
    endtask

    task automatic test_frame_count_limits();
        // Zero acts as one frame
        write_register(ADDR_FRAME_COUNT, APB_DATA_W'(0));
        send_pages('{16'h0003, 16'h0003, 16'h0004});
        drain_results();
        // Above the frame total saturates
        write_register(ADDR_FRAME_COUNT, APB_DATA_W'(15));
        write_register(ADDR_POLICY, APB_DATA_W'(POLICY_LRU));
        send_pages('{16'h0001, 16'h0002});
        drain_results();
    endtask

    // Locality-heavy traffic: mostly a working set a bit larger than the frames
    task automatic run_traffic_phase(input int items);
        logic [PAGE_BITS-1:0] working_set [12];
        logic [PAGE_BITS-1:0] page;
        int                   set_size;
        set_size = active_frames() + $urandom_range(1, 4);
        foreach (working_set[i]) working_set[i] = PAGE_BITS'($urandom);
        if ($urandom_range(0, 3) == 0) working_set[0] = '0;
        for (int i = 0; i < items; i++) begin
            case ($urandom_range(0, 9))
                0:       page = PAGE_BITS'($urandom);
                1:       page = $urandom_range(0, 1) ? '0 : '1;
                default: page = working_set[$urandom_range(0, set_size - 1)];
            endcase
            send_page_request(page);
            pace_sender();
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [FRAME_COUNT_W-1:0] count;
        logic                     policy;
        logic [APB_DATA_W-1:0]    noise;
        for (int phase = 0; phase < 16; phase++) begin
            case (phase)
                0:       begin count = 4'd1;  policy = POLICY_FIFO; end
                1:       begin count = 4'd8;  policy = POLICY_LRU;  end
                2:       begin count = 4'd0;  policy = POLICY_LRU;  end
                3:       begin count = 4'd15; policy = POLICY_FIFO; end
                default: begin
                    count  = FRAME_COUNT_W'($urandom_range(0, 15));
                    policy = 1'($urandom_range(0, 1));
                end
            endcase
            // Upper data bits are ignored by both registers
            noise = APB_DATA_W'($urandom);
            write_register(ADDR_FRAME_COUNT, {noise[APB_DATA_W-1:FRAME_COUNT_W], count});
            noise = APB_DATA_W'($urandom);
            write_register(ADDR_POLICY, {noise[APB_DATA_W-1:1], policy});
            gaps_enabled = ($urandom_range(0, 3) != 0);
            run_traffic_phase(125);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req.valid       = 1'b0;
        req.page_number = '0;
        model_frame_count = FRAME_COUNT_RST;
        model_policy      = POLICY_RST;
        clear_frames();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_lru_fill_and_evict();
        test_fifo_small();
        test_frame_count_limits();
        test_random_traffic();

        drain_results();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
